/* src/pip_pkg.sv */
// Package for the point-in-polygon test block.
// Holds command codes, fixed field widths and the queue entry control type.
// No dependencies.
`timescale 1ns / 1ps

package pip_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    localparam int VCOUNT_W = 7;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd3;

    typedef struct packed {
        logic              is_test;
        logic              wr_ok;
        logic [SLOT_W-1:0] slot;
    } pip_cmd_t;

endpackage

/* src/pip_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/pip_front.sv */
// Front end of the point-in-polygon test: accepts beats, classifies them and
// holds them in a two-entry queue for the back end. Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_front
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         cmd,
    input  logic [SLOT_W-1:0]            vertex_index,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    output logic                         q_valid,
    output pip_cmd_t                     q_cmd,
    output logic signed [COORD_BITS-1:0] q_x,
    output logic signed [COORD_BITS-1:0] q_y,
    input  logic                         q_pop
);

    pip_cmd_t                     ent_cmd_reg [2];
    logic signed [COORD_BITS-1:0] ent_x_reg [2];
    logic signed [COORD_BITS-1:0] ent_y_reg [2];
    logic                         wr_ptr_reg;
    logic                         rd_ptr_reg;
    logic [1:0]                   level_reg;
    logic [1:0]                   level_next;
    logic                         push;
    logic                         slot_ok;
    pip_cmd_t                     in_cmd;

    assign slot_ok = (MAX_VERTICES >= (1 << SLOT_W)) ? 1'b1
                   : (vertex_index < SLOT_W'(MAX_VERTICES));

    always_comb
    begin
        in_cmd.is_test = (cmd == CMD_TEST);
        in_cmd.wr_ok   = slot_ok;
        in_cmd.slot    = vertex_index;
    end

    assign item_stall = (level_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign q_valid    = (level_reg != 2'd0);
    assign q_cmd      = ent_cmd_reg[rd_ptr_reg];
    assign q_x        = ent_x_reg[rd_ptr_reg];
    assign q_y        = ent_y_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !q_pop)
        begin
            level_next = level_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_cmd_reg[wr_ptr_reg] <= in_cmd;
            ent_x_reg[wr_ptr_reg]   <= point_x;
            ent_y_reg[wr_ptr_reg]   <= point_y;
        end
    end

endmodule

/* src/pip_back.sv */
// Back end of the point-in-polygon test: vertex store, bounding box pass,
// pipelined edge crossing pass and the result register.
// Depends on pip_pkg and pip_ram.
`timescale 1ns / 1ps

module pip_back
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [VCOUNT_W-1:0]          cfg_wr_data,
    input  logic                         q_valid,
    input  pip_cmd_t                     q_cmd,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    output logic                         q_pop,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         inside_res,
    output logic                         in_box,
    output logic [COUNT_W-1:0]           crossing_count
);

    localparam int C  = COORD_BITS;
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int IW = $clog2(MAX_VERTICES + 2);
    localparam int CW = (IW > VCOUNT_W) ? IW : VCOUNT_W;
    localparam int DW = C + 3;
    localparam int PW = 2 * DW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BOX  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_EDGE = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [VCOUNT_W-1:0]    vcount_reg;
    logic [IW-1:0]          n_reg;
    logic [IW-1:0]          n_eff;
    logic [CW-1:0]          vc_ext;
    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          idx_next;
    logic [COUNT_W-1:0]     cnt_reg;
    logic [COUNT_W-1:0]     cnt_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [2*C-1:0]         ram_rdata;

    logic                   iss;
    logic                   iss_first;
    logic                   iss_last;
    logic                   dv_reg;
    logic                   df_reg;
    logic                   dl_reg;

    logic signed [C-1:0]    vx;
    logic signed [C-1:0]    vy;
    logic signed [C-1:0]    px_reg;
    logic signed [C-1:0]    py_reg;
    logic signed [C-1:0]    left_reg;
    logic signed [C-1:0]    right_reg;
    logic signed [C-1:0]    bot_reg;
    logic signed [C-1:0]    top_reg;
    logic signed [C-1:0]    prevx_reg;
    logic signed [C-1:0]    prevy_reg;
    logic signed [C+1:0]    rx_w;
    logic signed [C+1:0]    rx_reg;
    logic                   box_hit;
    logic                   ray_pos;

    logic signed [DW-1:0]   vx_e;
    logic signed [DW-1:0]   vy_e;
    logic signed [DW-1:0]   prevx_e;
    logic signed [DW-1:0]   prevy_e;
    logic signed [DW-1:0]   px_e;
    logic signed [DW-1:0]   py_e;
    logic signed [DW-1:0]   rx_e;

    logic                   e1_vld_reg;
    logic                   e1_last_reg;
    logic                   e1_str_reg;
    logic signed [DW-1:0]   dcx_reg;
    logic signed [DW-1:0]   dcy_reg;
    logic signed [DW-1:0]   pcy_reg;
    logic signed [DW-1:0]   pcx_reg;
    logic signed [DW-1:0]   rcx_reg;

    logic                   e2_vld_reg;
    logic                   e2_last_reg;
    logic                   e2_str_reg;
    logic signed [PW-1:0]   p_reg;
    logic signed [PW-1:0]   q1_reg;
    logic signed [PW-1:0]   q2_reg;
    logic                   crossed;

    logic                   res_inside_reg;
    logic                   res_box_reg;
    logic [COUNT_W-1:0]     res_cnt_reg;
    logic                   ov_reg;
    logic                   o_inside_reg;
    logic                   o_box_reg;
    logic [COUNT_W-1:0]     o_cnt_reg;
    logic                   out_free;
    logic                   load_out;

    pip_ram #(
        .WIDTH (2 * C),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({q_x, q_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_waddr = AW'(q_cmd.slot);
    assign vx        = $signed(ram_rdata[2*C-1:C]);
    assign vy        = $signed(ram_rdata[C-1:0]);

    assign vc_ext = CW'(vcount_reg);
    always_comb
    begin
        if (vc_ext == '0)
        begin
            n_eff = IW'(1);
        end
        else if (vc_ext > CW'(MAX_VERTICES))
        begin
            n_eff = IW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = IW'(vc_ext);
        end
    end

    assign vx_e    = DW'(vx);
    assign vy_e    = DW'(vy);
    assign prevx_e = DW'(prevx_reg);
    assign prevy_e = DW'(prevy_reg);
    assign px_e    = DW'(px_reg);
    assign py_e    = DW'(py_reg);
    assign rx_e    = DW'(rx_reg);

    assign box_hit = (px_reg >= left_reg) && (px_reg <= right_reg)
                  && (py_reg >= bot_reg) && (py_reg <= top_reg);
    assign rx_w    = ((C + 2)'(right_reg) <<< 1) - (C + 2)'(left_reg);
    assign ray_pos = (rx_e > px_e);

    // The ray's own orientation tests reduce to which side of the ray each
    // endpoint lies on; the edge's tests need the two cross products.
    assign crossed = ray_pos && e2_str_reg && ((p_reg > q1_reg) != (p_reg > q2_reg));

    assign out_free = !ov_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        iss        = 1'b0;
        iss_first  = 1'b0;
        iss_last   = 1'b0;
        ram_raddr  = '0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.is_test)
                    begin
                        state_next = ST_BOX;
                        idx_next   = '0;
                    end
                    else
                    begin
                        ram_we = q_cmd.wr_ok;
                    end
                end
            end
            ST_BOX:
            begin
                if (idx_reg < n_reg)
                begin
                    iss       = 1'b1;
                    ram_raddr = idx_reg[AW-1:0];
                    iss_first = (idx_reg == '0);
                    iss_last  = (idx_reg == n_reg - IW'(1));
                    idx_next  = idx_reg + IW'(1);
                end
                if (dv_reg && dl_reg)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                cnt_next = '0;
                idx_next = '0;
                if (box_hit)
                begin
                    state_next = ST_EDGE;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_EDGE:
            begin
                if (idx_reg <= n_reg)
                begin
                    iss       = 1'b1;
                    ram_raddr = (idx_reg == n_reg) ? '0 : idx_reg[AW-1:0];
                    iss_first = (idx_reg == '0);
                    iss_last  = (idx_reg == n_reg);
                    idx_next  = idx_reg + IW'(1);
                end
                if (e2_vld_reg)
                begin
                    cnt_next = cnt_reg + COUNT_W'(crossed);
                    if (e2_last_reg)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vcount_reg <= VCOUNT_RESET;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            dv_reg     <= 1'b0;
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            dv_reg     <= iss;
            e1_vld_reg <= (state_reg == ST_EDGE) && dv_reg && !df_reg;
            e2_vld_reg <= e1_vld_reg;
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        df_reg <= iss_first;
        dl_reg <= iss_last;
        if (state_reg == ST_IDLE && q_valid && q_cmd.is_test)
        begin
            px_reg <= q_x;
            py_reg <= q_y;
            n_reg  <= n_eff;
        end
        if (state_reg == ST_BOX && dv_reg)
        begin
            if (df_reg || vx < left_reg)
            begin
                left_reg <= vx;
            end
            if (df_reg || vx > right_reg)
            begin
                right_reg <= vx;
            end
            if (df_reg || vy < bot_reg)
            begin
                bot_reg <= vy;
            end
            if (df_reg || vy > top_reg)
            begin
                top_reg <= vy;
            end
        end
        if (state_reg == ST_CHK)
        begin
            rx_reg         <= rx_w;
            res_inside_reg <= 1'b0;
            res_box_reg    <= 1'b0;
            res_cnt_reg    <= '0;
        end
        if (state_reg == ST_EDGE && dv_reg)
        begin
            prevx_reg   <= vx;
            prevy_reg   <= vy;
            e1_last_reg <= dl_reg;
            e1_str_reg  <= (prevy_reg > py_reg) != (vy > py_reg);
            dcx_reg     <= vx_e - prevx_e;
            dcy_reg     <= vy_e - prevy_e;
            pcy_reg     <= py_e - prevy_e;
            pcx_reg     <= px_e - prevx_e;
            rcx_reg     <= rx_e - prevx_e;
        end
        e2_last_reg <= e1_last_reg;
        e2_str_reg  <= e1_str_reg;
        p_reg       <= dcx_reg * pcy_reg;
        q1_reg      <= dcy_reg * pcx_reg;
        q2_reg      <= dcy_reg * rcx_reg;
        if (state_reg == ST_EDGE && e2_vld_reg && e2_last_reg)
        begin
            res_inside_reg <= cnt_next[0];
            res_box_reg    <= 1'b1;
            res_cnt_reg    <= cnt_next;
        end
        if (load_out)
        begin
            o_inside_reg <= res_inside_reg;
            o_box_reg    <= res_box_reg;
            o_cnt_reg    <= res_cnt_reg;
        end
    end

    assign result_valid   = ov_reg;
    assign inside_res     = o_inside_reg;
    assign in_box         = o_box_reg;
    assign crossing_count = o_cnt_reg;

endmodule

/* src/point_in_polygon_test_top.sv */
// A test beat runs a bounding box pass over the n vertices and, only when the point lies inside
// the bounding box, an edge crossing pass, n the vertex count.
// The back end takes no new beat until a test has finished, since both passes share the single
// read port of the vertex store; a load beat is written to the vertex store as it is popped.
// Reset (rst_n, asynchronous, active low) empties the queue and the result register and
// sets vertex_count to 3; the vertex store is not cleared.
`timescale 1ns / 1ps

module point_in_polygon_test_top
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [VCOUNT_W-1:0]          cfg_wr_data,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         cmd,
    input  logic [SLOT_W-1:0]            vertex_index,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         inside_res,
    output logic                         in_box,
    output logic [COUNT_W-1:0]           crossing_count
);

    logic                         q_valid;
    logic                         q_pop;
    pip_cmd_t                     q_cmd;
    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;

    pip_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .vertex_index (vertex_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_pop        (q_pop)
    );

    pip_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_x            (q_x),
        .q_y            (q_y),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .inside_res     (inside_res),
        .in_box         (in_box),
        .crossing_count (crossing_count)
    );

`ifndef SYNTH
    // A point inside the polygon must be inside its box with an odd count.
    a_inside_parity: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (inside_res == (in_box && crossing_count[0])))
        else $error("inside_res disagrees with in_box and crossing parity");

    // A point outside the box reports no crossings.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !in_box) |-> (crossing_count == '0))
        else $error("crossing_count nonzero outside the bounding box");

    // The queue can only fill up right after it takes a beat.
    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(item_valid && !item_stall))
        else $error("queue became full without an accepted beat");
`endif

endmodule

/* sim/point_in_polygon_test_top_test.sv */
// Self-checking testbench for point_in_polygon_test_top: vertex loads and point tests are
// driven in random bursts, results are taken under random stalls and checked against an
// in-bench ray-crossing predictor. Depends on pip_pkg and the block's RTL.
`timescale 1ns / 1ps

module point_in_polygon_test_top_test;
    import pip_pkg::*;

    localparam int MAX_VERT    = 64;
    localparam int COORD_W     = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 2 * MAX_VERT + 20;

    typedef struct {
        logic                      cmd;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } poly_beat_t;

    typedef struct {
        logic               is_in;
        logic               boxed;
        logic [COUNT_W-1:0] hits;
    } verdict_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [VCOUNT_W-1:0]        cfg_wr_data = '0;
    logic                       item_valid = 1'b0;
    logic                       item_stall;
    logic                       cmd = CMD_LOAD;
    logic [SLOT_W-1:0]          vertex_index = '0;
    logic signed [COORD_W-1:0]  point_x = '0;
    logic signed [COORD_W-1:0]  point_y = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic                       inside_res;
    logic                       in_box;
    logic [COUNT_W-1:0]         crossing_count;

    poly_beat_t queued_beats[$];
    verdict_t   owed_verdicts[$];

    logic signed [COORD_W-1:0] poly_x [MAX_VERT];
    logic signed [COORD_W-1:0] poly_y [MAX_VERT];
    logic [VCOUNT_W-1:0]       poly_count = VCOUNT_RESET;

    logic signed [COORD_W-1:0] plan_x [MAX_VERT];
    logic signed [COORD_W-1:0] plan_y [MAX_VERT];
    bit                        plan_known [MAX_VERT];
    int                        plan_n = 3;

    int fail_cnt = 0;
    int cycle_cnt = 0;
    int burst_left = 0;
    int gap_left = 0;
    int taken = 0;
    int squeeze_left = 0;
    int squeezes_done = 0;
    int mode_left = 0;
    int stall_mode = 0;

    point_in_polygon_test_top #(
        .MAX_VERTICES(MAX_VERT),
        .COORD_BITS  (COORD_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .cmd           (cmd),
        .vertex_index  (vertex_index),
        .point_x       (point_x),
        .point_y       (point_y),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .inside_res    (inside_res),
        .in_box        (in_box),
        .crossing_count(crossing_count)
    );

    always #5 clk = ~clk;

    function automatic int active_vertices(input logic [VCOUNT_W-1:0] raw);
        if (raw == 0)
        begin
            return 1;
        end
        if (raw > MAX_VERT)
        begin
            return MAX_VERT;
        end
        return int'(raw);
    endfunction

    // A collinear turn counts as clockwise.
    function automatic int turn(input longint ax, input longint ay, input longint bx,
                                input longint by, input longint cx, input longint cy);
        return ((bx - ax) * (cy - ay) > (by - ay) * (cx - ax)) ? 1 : -1;
    endfunction

    function automatic bit segs_cross(input longint ax, input longint ay, input longint bx,
                                      input longint by, input longint cx, input longint cy,
                                      input longint dx, input longint dy);
        return turn(ax, ay, bx, by, cx, cy) != turn(ax, ay, bx, by, dx, dy)
            && turn(cx, cy, dx, dy, ax, ay) != turn(cx, cy, dx, dy, bx, by);
    endfunction

    task automatic apply_beat(input poly_beat_t b);
        longint   px, py, lft, rgt, bot, top, ray_end;
        int       n, j, hits;
        verdict_t v;
        if (b.cmd == CMD_LOAD)
        begin
            poly_x[b.slot] = b.x;
            poly_y[b.slot] = b.y;
        end
        else
        begin
            n = active_vertices(poly_count);
            px = b.x;
            py = b.y;
            lft = poly_x[0];
            rgt = poly_x[0];
            bot = poly_y[0];
            top = poly_y[0];
            for (int i = 1; i < n; i++)
            begin
                if (poly_x[i] < lft) lft = poly_x[i];
                if (poly_x[i] > rgt) rgt = poly_x[i];
                if (poly_y[i] < bot) bot = poly_y[i];
                if (poly_y[i] > top) top = poly_y[i];
            end
            v.is_in = 1'b0;
            v.boxed = 1'b0;
            v.hits = '0;
            if (px >= lft && px <= rgt && py >= bot && py <= top)
            begin
                ray_end = 2 * rgt - lft;
                hits = 0;
                for (int i = 0; i < n; i++)
                begin
                    j = (i + 1 < n) ? i + 1 : 0;
                    if (segs_cross(px, py, ray_end, py, poly_x[i], poly_y[i],
                                   poly_x[j], poly_y[j]))
                    begin
                        hits++;
                    end
                end
                v.is_in = hits[0];
                v.boxed = 1'b1;
                v.hits = COUNT_W'(hits);
            end
            owed_verdicts.push_back(v);
        end
    endtask

    always @(posedge clk)
    begin : sender
        logic fire;
        logic go;
        fire = item_valid && !item_stall;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                apply_beat(queued_beats.pop_front());
            end
            if (item_valid && !fire)
            begin
                go = 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                go = 1'b0;
            end
            else if (queued_beats.size() == 0)
            begin
                go = 1'b0;
            end
            else
            begin
                go = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 3);
                        2: gap_left = $urandom_range(4, 12);
                        default: gap_left = $urandom_range(13, 30);
                    endcase
                end
            end
            item_valid <= go;
            if (go)
            begin
                cmd <= queued_beats[0].cmd;
                vertex_index <= queued_beats[0].slot;
                point_x <= queued_beats[0].x;
                point_y <= queued_beats[0].y;
            end
        end
    end

    always @(posedge clk)
    begin : receiver
        logic hold;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                taken++;
            end
            if (squeeze_left == 0 && squeezes_done < 2 && taken >= 40 + 200 * squeezes_done
                && item_valid && result_valid)
            begin
                squeeze_left = 700;
                squeezes_done++;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: hold = 1'b0;
                1: hold = ($urandom_range(0, 1) != 0);
                2: hold = ($urandom_range(0, 3) != 0);
                default: hold = ~result_stall;
            endcase
            if (squeeze_left > 0)
            begin
                hold = 1'b1;
                squeeze_left--;
            end
            result_stall <= hold;
        end
    end

    always @(posedge clk)
    begin : result_mon
        verdict_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (owed_verdicts.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: inside=%0d in_box=%0d count=%0d",
                         $time, inside_res, in_box, crossing_count);
                fail_cnt++;
            end
            else
            begin
                want = owed_verdicts.pop_front();
                if (inside_res !== want.is_in)
                begin
                    $display("%0t: inside_res expected %0d actual %0d",
                             $time, want.is_in, inside_res);
                    fail_cnt++;
                end
                if (in_box !== want.boxed)
                begin
                    $display("%0t: in_box expected %0d actual %0d", $time, want.boxed, in_box);
                    fail_cnt++;
                end
                if (crossing_count !== want.hits)
                begin
                    $display("%0t: crossing_count expected %0d actual %0d",
                             $time, want.hits, crossing_count);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_load(input int slot, input int x, input int y);
        poly_beat_t b;
        b.cmd = CMD_LOAD;
        b.slot = SLOT_W'(slot);
        b.x = COORD_W'(x);
        b.y = COORD_W'(y);
        plan_x[slot] = b.x;
        plan_y[slot] = b.y;
        plan_known[slot] = 1'b1;
        queued_beats.push_back(b);
    endtask

    task automatic queue_test(input int x, input int y);
        poly_beat_t b;
        b.cmd = CMD_TEST;
        b.slot = SLOT_W'($urandom_range(0, MAX_VERT - 1));
        b.x = COORD_W'(x);
        b.y = COORD_W'(y);
        queued_beats.push_back(b);
    endtask

    function automatic int rand_coord(input int scale);
        case (scale)
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 16)) - 8;
            2: return int'($urandom_range(0, 4000)) - 2000;
            default: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        endcase
    endfunction

    task automatic pick_point(output int px, output int py);
        int lo_x, hi_x, lo_y, hi_y, k;
        lo_x = plan_x[0];
        hi_x = plan_x[0];
        lo_y = plan_y[0];
        hi_y = plan_y[0];
        for (int i = 1; i < plan_n; i++)
        begin
            if (plan_x[i] < lo_x) lo_x = plan_x[i];
            if (plan_x[i] > hi_x) hi_x = plan_x[i];
            if (plan_y[i] < lo_y) lo_y = plan_y[i];
            if (plan_y[i] > hi_y) hi_y = plan_y[i];
        end
        k = $urandom_range(0, plan_n - 1);
        px = lo_x + int'($urandom_range(0, hi_x - lo_x));
        py = lo_y + int'($urandom_range(0, hi_y - lo_y));
        case ($urandom_range(0, 9))
            0:
            begin
                px = plan_x[k];
                py = plan_y[k];
            end
            1, 2: py = plan_y[k];
            3:
            begin
                px = rand_coord(0);
                py = rand_coord(0);
            end
            4: px = ($urandom_range(0, 1) != 0) ? lo_x : hi_x;
            default: ;
        endcase
    endtask

    task automatic settle();
        while (queued_beats.size() != 0 || owed_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_vertex_count(input logic [VCOUNT_W-1:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        poly_count = value;
        plan_n = active_vertices(value);
    endtask

    task automatic random_phase(input logic [VCOUNT_W-1:0] value, input int n_beats);
        int made, scale, k, px, py;
        set_vertex_count(value);
        for (int i = 0; i < plan_n; i++)
        begin
            if (!plan_known[i])
            begin
                queue_load(i, rand_coord(2), rand_coord(2));
            end
        end
        made = 0;
        while (made < n_beats)
        begin
            if ($urandom_range(0, 9 + plan_n) < 2)
            begin
                scale = $urandom_range(0, 3);
                for (int i = 0; i < plan_n; i++)
                begin
                    queue_load(i, rand_coord(scale), rand_coord(scale));
                end
                made += plan_n;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                queue_load($urandom_range(0, MAX_VERT - 1), rand_coord(0), rand_coord(0));
                made++;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k)
                begin
                    pick_point(px, py);
                    queue_test(px, py);
                end
                made += k;
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        queue_load(0, -32768, -32768);
        queue_load(1, 32767, -32768);
        queue_load(2, 0, 32767);
        queue_test(0, 0);
        queue_test(32767, 32767);
        queue_test(-32768, -32768);
        queue_test(32767, -32768);
        queue_test(-1, -32768);
        queue_test(0, 32767);
        queue_load(2, 0, 100);
        queue_test(0, 101);
        queue_test(-32768, 0);
        queue_test(100, 50);
        queue_load(63, -1, 0);
        set_vertex_count(VCOUNT_W'(1));
        queue_test(-32768, -32768);
        queue_test(0, 0);
        set_vertex_count(VCOUNT_W'(0));
        queue_test(-32768, -32768);

        random_phase(VCOUNT_W'(5), 80);
        random_phase(VCOUNT_W'(64), 120);
        random_phase(VCOUNT_W'(127), 50);
        random_phase(VCOUNT_W'(1), 40);
        random_phase(VCOUNT_W'(2), 50);
        repeat (9)
        begin
            random_phase(VCOUNT_W'($urandom_range(3, 12)), 60);
        end
        random_phase(VCOUNT_W'($urandom_range(65, 126)), 40);
        random_phase(VCOUNT_W'(0), 30);

        settle();
        if (fail_cnt == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
